FILE: rtl/mbp_pkg.sv
// Package of types and constants shared by the mode, bank and palette register block.
package mbp_pkg;

    // Colour RAM geometry.
    localparam int PALETTE_BYTES = 64;
    localparam int PAL_AW        = $clog2(PALETTE_BYTES);

    // Access direction codes.
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Register select codes.
    localparam logic [2:0] SEL_MODE      = 3'd0;
    localparam logic [2:0] SEL_SPEED     = 3'd1;
    localparam logic [2:0] SEL_VBANK     = 3'd2;
    localparam logic [2:0] SEL_PAL_INDEX = 3'd3;
    localparam logic [2:0] SEL_PAL_DATA  = 3'd4;
    localparam logic [2:0] SEL_PRIORITY  = 3'd5;
    localparam logic [2:0] SEL_WBANK     = 3'd6;

    // Read values and masks.
    localparam logic [7:0] MODE_LOCKED_READ = 8'hFF;
    localparam logic [7:0] MODE_COLOUR_READ = 8'h00;
    localparam logic [7:0] MODE_COMPAT_READ = 8'h04;
    localparam logic [7:0] ONE_BIT_FILL     = 8'hFE;
    localparam logic [7:0] WBANK_FILL       = 8'hF8;
    localparam logic [7:0] UNMAPPED_READ    = 8'hFF;
    localparam logic [7:0] PAL_INDEX_RESET  = 8'h40;

    // One bus access request.
    typedef struct packed {
        logic       action;
        logic [2:0] register_select;
        logic [7:0] write_data;
        logic       speed_status;
    } mbp_req_t;

    // One access result.
    typedef struct packed {
        logic [7:0] read_data;
        logic       color_mode;
        logic       mode_locked;
        logic       switch_armed;
        logic       video_bank;
        logic [2:0] work_bank;
        logic       priority_mode;
        logic [5:0] palette_address;
    } mbp_result_t;

endpackage

FILE: rtl/mode_bank_palette_register_block_top.sv
// Top level of the mode, bank and palette register block.
//
// Seven byte-wide bus registers: a write-once compatibility mode register, a speed
// switch, a video bank select, a palette index with optional auto-increment, a
// palette data port into a 64-byte colour RAM, an object priority bit and a work-RAM
// bank select. Every request returns one result: the byte read (zero for writes)
// and the decoded mode and bank state after the request. A request passes through an
// input register and is resolved into the result register once that is free, so the
// block takes one request per cycle while m_ready holds no earlier result back; the
// result is offered from the result register and waits there for m_ready. The
// colour RAM is cleared at reset by a per-entry valid bit, so there is no clearing
// pass; its read port is registered alongside the result register.
module mode_bank_palette_register_block_top (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mbp_pkg::mbp_req_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mbp_pkg::mbp_result_t m_data
);
    import mbp_pkg::*;

    // Input register.
    logic     in_valid_reg;
    mbp_req_t in_reg;

    // Result register.
    logic        out_valid_reg;
    mbp_result_t out_reg;
    logic        out_from_ram_reg;

    // Block state.
    logic       lock_reg,     lock_next;
    logic       colour_reg,   colour_next;
    logic       armed_reg,    armed_next;
    logic [5:0] spare_reg,    spare_next;
    logic       vbank_reg,    vbank_next;
    logic [7:0] pal_idx_reg,  pal_idx_next;
    logic       prio_reg,     prio_next;
    logic [2:0] wbank_reg,    wbank_next;

    // Colour RAM, its valid bits and its registered read port.
    logic [7:0]         pal_ram [PALETTE_BYTES];
    logic [PALETTE_BYTES-1:0] pal_valid_reg;
    logic [7:0]         ram_rd_reg;
    logic               ram_rd_valid_reg;

    logic              advance;
    logic              is_write;
    logic              ram_wr;
    logic [PAL_AW-1:0] slot;
    logic [7:0]        rd_value;
    logic              rd_from_ram;
    mbp_result_t       result_next;

    // Handshake: the input register moves on whenever the result register is free.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;

    assign is_write = (in_reg.action == ACT_WRITE);
    assign slot     = pal_idx_reg[PAL_AW-1:0];
    assign ram_wr   = advance && is_write && (in_reg.register_select == SEL_PAL_DATA);

    // Register writes.
    always_comb begin
        lock_next    = lock_reg;
        colour_next  = colour_reg;
        armed_next   = armed_reg;
        spare_next   = spare_reg;
        vbank_next   = vbank_reg;
        pal_idx_next = pal_idx_reg;
        prio_next    = prio_reg;
        wbank_next   = wbank_reg;
        if (is_write) begin
            case (in_reg.register_select)
                SEL_MODE: begin
                    if (!lock_reg) begin
                        colour_next = ~in_reg.write_data[2];
                        lock_next   = 1'b1;
                    end
                end
                SEL_SPEED: begin
                    armed_next = in_reg.write_data[0];
                    spare_next = in_reg.write_data[6:1];
                end
                SEL_VBANK:     vbank_next   = in_reg.write_data[0];
                SEL_PAL_INDEX: pal_idx_next = in_reg.write_data | PAL_INDEX_RESET;
                SEL_PAL_DATA: begin
                    if (pal_idx_reg[7]) begin
                        pal_idx_next = {pal_idx_reg[7:6], pal_idx_reg[5:0] + 6'd1};
                    end
                end
                SEL_PRIORITY:  prio_next    = in_reg.write_data[0];
                SEL_WBANK:     wbank_next   = in_reg.write_data[2:0];
                default:       ;
            endcase
        end
    end

    // Register reads; the colour RAM byte is joined in after its registered read.
    always_comb begin
        rd_value    = 8'h00;
        rd_from_ram = 1'b0;
        if (!is_write) begin
            case (in_reg.register_select)
                SEL_MODE: begin
                    if (lock_reg) begin
                        rd_value = MODE_LOCKED_READ;
                    end else begin
                        rd_value = colour_reg ? MODE_COLOUR_READ : MODE_COMPAT_READ;
                    end
                end
                SEL_SPEED:     rd_value = {in_reg.speed_status, spare_reg, armed_reg};
                SEL_VBANK:     rd_value = ONE_BIT_FILL | {7'd0, vbank_reg};
                SEL_PAL_INDEX: rd_value = pal_idx_reg;
                SEL_PAL_DATA:  rd_from_ram = 1'b1;
                SEL_PRIORITY:  rd_value = ONE_BIT_FILL | {7'd0, prio_reg};
                SEL_WBANK:     rd_value = WBANK_FILL | {5'd0, wbank_reg};
                default:       rd_value = UNMAPPED_READ;
            endcase
        end
    end

    // Result fields reflect the state after the request.
    always_comb begin
        result_next                 = '0;
        result_next.read_data       = rd_value;
        result_next.color_mode      = colour_next;
        result_next.mode_locked     = lock_next;
        result_next.switch_armed    = armed_next;
        result_next.video_bank      = vbank_next;
        result_next.work_bank       = (wbank_next == 3'd0) ? 3'd1 : wbank_next;
        result_next.priority_mode   = prio_next;
        result_next.palette_address = pal_idx_next[5:0];
    end

    // Control, state and valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            lock_reg         <= 1'b0;
            colour_reg       <= 1'b1;
            armed_reg        <= 1'b0;
            spare_reg        <= 6'd0;
            vbank_reg        <= 1'b0;
            pal_idx_reg      <= PAL_INDEX_RESET;
            prio_reg         <= 1'b0;
            wbank_reg        <= 3'd0;
            pal_valid_reg    <= '0;
            ram_rd_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg    <= 1'b1;
                lock_reg         <= lock_next;
                colour_reg       <= colour_next;
                armed_reg        <= armed_next;
                spare_reg        <= spare_next;
                vbank_reg        <= vbank_next;
                pal_idx_reg      <= pal_idx_next;
                prio_reg         <= prio_next;
                wbank_reg        <= wbank_next;
                ram_rd_valid_reg <= pal_valid_reg[slot];
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (ram_wr) begin
                pal_valid_reg[slot] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg          <= result_next;
            out_from_ram_reg <= rd_from_ram;
        end
    end

    // Colour RAM: one write and one registered read per cycle, each only as a request advances.
    always_ff @(posedge aclk) begin
        if (ram_wr) begin
            pal_ram[slot] <= in_reg.write_data;
        end
        if (advance) begin
            ram_rd_reg <= pal_ram[slot];
        end
    end

    // Output payload, with the colour RAM byte substituted for palette data reads.
    always_comb begin
        m_data = out_reg;
        if (out_from_ram_reg) begin
            m_data.read_data = ram_rd_valid_reg ? ram_rd_reg : 8'h00;
        end
    end

endmodule
